// ===== rtl/srfo_pkg.sv =====
// ----------------------------------------------------------------------------
// srfo_pkg
// Shared types and constants of the overwriting sample ring FIFO.
// ----------------------------------------------------------------------------
`default_nettype none

package srfo_pkg;

    // field widths
    localparam int unsigned OPT_W    = 18;
    localparam int unsigned ACC_W    = 16;
    localparam int unsigned REC_W    = 2 * OPT_W + 3 * ACC_W;
    localparam int unsigned OCC_W    = 8;
    localparam int unsigned DROP_W   = 16;
    localparam int unsigned IN_DW    = 88;
    localparam int unsigned OUT_DW   = 112;
    localparam int unsigned OUT_UW   = 2;

    // saturation value of the drop counter
    localparam logic [DROP_W-1:0] DROP_MAX = '1;

    // operation carried in the input tuser
    typedef enum logic [0:0] {
        OP_ENQ = 1'b0,
        OP_DEQ = 1'b1
    } t_op;

    // result status carried in the output tuser
    typedef enum logic [1:0] {
        ST_STORED    = 2'd0,
        ST_DROPPED   = 2'd1,
        ST_READ_OK   = 2'd2,
        ST_UNDERFLOW = 2'd3
    } t_status;

    // one sensor record, ir in the lowest bits
    typedef struct packed {
        logic signed [ACC_W-1:0] accel_z;
        logic signed [ACC_W-1:0] accel_y;
        logic signed [ACC_W-1:0] accel_x;
        logic        [OPT_W-1:0] red;
        logic        [OPT_W-1:0] ir;
    } t_record;

    // controller states
    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_BUSY = 2'b10
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic commit;
    } t_ctl_cmd;

    // datapath to controller
    typedef struct packed {
        logic out_free;
    } t_dp_stat;

endpackage

`default_nettype wire

// ===== rtl/srfo_ram.sv =====
// ----------------------------------------------------------------------------
// srfo_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module srfo_ram #(
    parameter int unsigned WIDTH = 68,
    parameter int unsigned DEPTH = 128
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port, holds while not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/srfo_ctrl.sv =====
// ----------------------------------------------------------------------------
// srfo_ctrl
// Controller: takes one operation, then commits it once the output is free.
// ----------------------------------------------------------------------------
`default_nettype none

module srfo_ctrl (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire srfo_pkg::t_dp_stat  i_stat,
    output srfo_pkg::t_ctl_cmd       o_cmd
);

    import srfo_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign o_in_ready  = (r_state == S_IDLE);
    assign accept      = i_in_valid && o_in_ready;
    assign o_cmd.capture = accept;
    assign o_cmd.commit  = (r_state == S_BUSY) && i_stat.out_free;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_BUSY;
                end
            end
            S_BUSY: begin
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/srfo_dp.sv =====
// ----------------------------------------------------------------------------
// srfo_dp
// Datapath: record store, pointers, fill and drop counters, output register.
// ----------------------------------------------------------------------------
`default_nettype none

module srfo_dp #(
    parameter int unsigned QUEUE_DEPTH = 128
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire srfo_pkg::t_ctl_cmd            i_cmd,
    output srfo_pkg::t_dp_stat                 o_stat,
    input  wire logic [srfo_pkg::IN_DW-1:0]    i_in_data,
    input  wire logic                          i_in_user,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic      [srfo_pkg::OUT_DW-1:0]   o_out_data,
    output logic      [srfo_pkg::OUT_UW-1:0]   o_out_user
);

    import srfo_pkg::*;

    localparam int unsigned PW = $clog2(QUEUE_DEPTH);
    localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(QUEUE_DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(QUEUE_DEPTH);

    // captured operation
    t_op         r_op;
    t_record     r_rec;

    // queue state
    logic [PW-1:0]     r_rd_ptr, n_rd_ptr;
    logic [PW-1:0]     r_wr_ptr, n_wr_ptr;
    logic [CW-1:0]     r_count,  n_count;
    logic [DROP_W-1:0] r_drop,   n_drop;

    // output register
    logic              r_out_valid;
    t_status           r_status, n_status;
    t_record           r_out_rec, n_out_rec;
    logic [OCC_W-1:0]  r_occ, n_occ;
    logic [DROP_W-1:0] r_out_drop;

    t_record           ram_rdata;
    logic              ram_we;
    logic [CW+OCC_W-1:0] occ_ext;

    assign o_stat.out_free = !r_out_valid || i_out_ready;

    // capture the incoming operation
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op  <= t_op'(i_in_user);
            r_rec <= t_record'(i_in_data[REC_W-1:0]);
        end
    end

    // record store, read issued with the capture
    assign ram_we = i_cmd.commit && (r_op == OP_ENQ);

    srfo_ram #(
        .WIDTH (REC_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_wr_ptr),
        .i_wdata (r_rec),
        .i_re    (i_cmd.capture),
        .i_raddr (r_rd_ptr),
        .o_rdata (ram_rdata)
    );

    // queue update and result
    always_comb begin
        n_rd_ptr  = r_rd_ptr;
        n_wr_ptr  = r_wr_ptr;
        n_count   = r_count;
        n_drop    = r_drop;
        n_out_rec = '0;
        n_status  = ST_UNDERFLOW;
        unique case (r_op)
            OP_ENQ: begin
                n_wr_ptr = (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
                if (r_count == CNT_FULL) begin
                    n_rd_ptr = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
                    if (r_drop != DROP_MAX) begin
                        n_drop = r_drop + 1'b1;
                    end
                    n_status = ST_DROPPED;
                end else begin
                    n_count  = r_count + 1'b1;
                    n_status = ST_STORED;
                end
            end
            OP_DEQ: begin
                if (r_count != '0) begin
                    n_out_rec = ram_rdata;
                    n_rd_ptr  = (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
                    n_count   = r_count - 1'b1;
                    n_status  = ST_READ_OK;
                end
            end
            default: n_status = ST_UNDERFLOW;
        endcase
        // occupancy keeps its low 8 bits
        occ_ext = {{OCC_W{1'b0}}, n_count};
        n_occ   = occ_ext[OCC_W-1:0];
    end

    // queue state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_ptr <= '0;
            r_wr_ptr <= '0;
            r_count  <= '0;
            r_drop   <= '0;
        end else if (i_cmd.commit) begin
            r_rd_ptr <= n_rd_ptr;
            r_wr_ptr <= n_wr_ptr;
            r_count  <= n_count;
            r_drop   <= n_drop;
        end
    end

    // output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_status   <= n_status;
            r_out_rec  <= n_out_rec;
            r_occ      <= n_occ;
            r_out_drop <= n_drop;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_user  = r_status;
    assign o_out_data  = {{(OUT_DW - REC_W - OCC_W - DROP_W){1'b0}},
                          r_out_drop, r_occ, r_out_rec};

endmodule

`default_nettype wire

// ===== rtl/sample_ring_fifo_overwrite.sv =====
// ----------------------------------------------------------------------------
// sample_ring_fifo_overwrite
// Ring FIFO of sensor records that drops the oldest record when full.
// ----------------------------------------------------------------------------
// Each input transfer is an enqueue (tuser 0) or a dequeue (tuser 1) and yields
// exactly one result transfer with a status, the record read (zero unless a
// dequeue succeeds), the occupancy after the operation and a saturating count
// of records dropped since reset. An enqueue into a full queue overwrites the
// oldest record. A dequeue on an empty queue reports underflow and changes
// nothing. One operation is in flight at a time: it is taken in the idle state
// and committed from the busy state, which covers the registered read of the
// record store; no new item is taken before that commit. The next item is
// accepted while an earlier result still waits in the output register; a
// stall there holds the commit. The store needs no clearing after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module sample_ring_fifo_overwrite #(
    parameter int unsigned QUEUE_DEPTH = 128
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    // ir_in[17:0], red_in[35:18], accel_x_in[51:36], accel_y_in[67:52],
    // accel_z_in[83:68], zero fill [87:84]
    input  wire logic [srfo_pkg::IN_DW-1:0]     s_axis_tdata,
    // opcode[0]
    input  wire logic                           s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    // ir_out[17:0], red_out[35:18], accel_x_out[51:36], accel_y_out[67:52],
    // accel_z_out[83:68], occupancy[91:84], dropped_total[107:92], zero [111:108]
    output logic      [srfo_pkg::OUT_DW-1:0]    m_axis_tdata,
    // status[1:0]
    output logic      [srfo_pkg::OUT_UW-1:0]    m_axis_tuser
);

    import srfo_pkg::*;

    t_ctl_cmd cmd;
    t_dp_stat stat;

    // controller
    srfo_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // datapath
    srfo_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_in_data   (s_axis_tdata),
        .i_in_user   (s_axis_tuser),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_data  (m_axis_tdata),
        .o_out_user  (m_axis_tuser)
    );

endmodule

`default_nettype wire

// ===== rtl/srfo_checker.sv =====
// ----------------------------------------------------------------------------
// srfo_checker
// Port-level checks of the overwriting sample ring FIFO, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module srfo_checker #(
    parameter int unsigned QUEUE_DEPTH = 128
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    input  wire logic [srfo_pkg::OUT_DW-1:0]    m_axis_tdata,
    input  wire logic [srfo_pkg::OUT_UW-1:0]    m_axis_tuser
);

    import srfo_pkg::*;

    localparam int unsigned OCC_LO = REC_W;
    localparam logic [OCC_W-1:0] FULL_OCC = OCC_W'(QUEUE_DEPTH);

    // underflow only happens on an empty queue
    a_underflow_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == ST_UNDERFLOW)
        |-> (m_axis_tdata[OCC_LO +: OCC_W] == '0))
        else $error("underflow reported with records held");

    // a drop leaves the queue full
    a_drop_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == ST_DROPPED)
        |-> (m_axis_tdata[OCC_LO +: OCC_W] == FULL_OCC))
        else $error("drop reported on a queue that is not full");

    // enqueue and underflow results carry an all-zero record
    a_zero_record: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser != ST_READ_OK)
        |-> (m_axis_tdata[REC_W-1:0] == '0))
        else $error("record fields set on a result without a read");

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result withdrawn before transfer");

endmodule

bind sample_ring_fifo_overwrite srfo_checker #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
) u_srfo_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
